// ===== rtl/tstf_pkg.sv =====
// Shared types and constants for the three-axis sine trajectory feed.
// Holds the register indexes, controller/datapath command types and the sine table.
// No dependencies.
package tstf_pkg;

  // Sine table geometry: one full turn over SINE_DEPTH entries.
  localparam int SINE_DEPTH = 1024;
  localparam int TBL_BITS   = $clog2(SINE_DEPTH);

  // Feed rate limits in 0.1 mm/min.
  localparam logic [24:0] FEED_MAX   = 25'h1FF_FFFF;
  localparam logic [24:0] FIRST_FEED = 25'd1000;

  // Square root of the scaled distance: operand width and step count.
  localparam int ROOT_N_W  = 52;
  localparam int ROOT_W    = ROOT_N_W / 2;
  localparam int ROOT_LAST = ROOT_W - 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
  localparam logic [2:0] REG_FRAME_RATE  = 3'd1;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd2;
  localparam logic [2:0] REG_U_WAVE      = 3'd3;
  localparam logic [2:0] REG_V_WAVE      = 3'd4;
  localparam logic [2:0] REG_W_WAVE      = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;
    logic       rd_sine;
    logic       mul;
    logic       pos;
    logic       sq;
    logic       scale1;
    logic       scale2;
    logic       root_step;
    logic       finish;
    logic [1:0] axis;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

  // Builds the Q15 sine table from a ninth-order series on the quarter wave.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t        rom;
    longint unsigned  p, quad, t, a, a2, u, s, q;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      p    = (longint'(k) << 32) / SINE_DEPTH;
      quad = (p >> 30) & 64'd3;
      t    = p & 64'h3FFF_FFFF;
      if (quad[0]) begin
        t = 64'd1073741824 - t;
      end
      a  = (t * 64'd1686629713) >> 30;
      a2 = (a * a) >> 30;
      u  = 64'd1073741824 - a2 / 72;
      u  = 64'd1073741824 - ((a2 * u) >> 30) / 42;
      u  = 64'd1073741824 - ((a2 * u) >> 30) / 20;
      u  = 64'd1073741824 - ((a2 * u) >> 30) / 6;
      s  = (a * u) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[k] = quad[1] ? -$signed(q[15:0]) : $signed(q[15:0]);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/tstf_ctrl.sv =====
// Controller of the trajectory feed: sequences the per-axis sine, scale
// and distance steps, the square root and the result hand-off. Uses tstf_pkg.
module tstf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output tstf_pkg::cmd_t cmd,
  input  tstf_pkg::sts_t sts
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SINE   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_POS    = 4'd3;
  localparam logic [3:0] ST_SQ     = 4'd4;
  localparam logic [3:0] ST_SCALE1 = 4'd5;
  localparam logic [3:0] ST_SCALE2 = 4'd6;
  localparam logic [3:0] ST_ROOT   = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam int ITER_W = $clog2(tstf_pkg::ROOT_W);

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state, counters and commands.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          axis_nxt  = 2'd0;
          state_nxt = ST_SINE;
        end
      end
      ST_SINE: begin
        cmd.rd_sine = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_SCALE1;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_SINE;
        end
      end
      ST_SCALE1: begin
        cmd.scale1 = 1'b1;
        state_nxt  = ST_SCALE2;
      end
      ST_SCALE2: begin
        cmd.scale2 = 1'b1;
        iter_nxt   = '0;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        iter_nxt      = iter_r + 1'b1;
        if (iter_r == ITER_W'(tstf_pkg::ROOT_LAST)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      iter_r  <= iter_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SINE && axis_r == 2'd0))
    else $error("accepted item did not start the sine step");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while the output register was full");
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != 2'd3)
    else $error("axis counter out of range");
  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE2) |-> ##(tstf_pkg::ROOT_W + 1) (state_r == ST_DONE))
    else $error("square root did not take the expected number of steps");
`endif

endmodule

// ===== rtl/tstf_dp.sv =====
// Datapath of the trajectory feed: configuration registers, sine table,
// axis scaling, distance, square root, frame state and output register. Uses tstf_pkg.
module tstf_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  tstf_pkg::cmd_t cmd,
  output tstf_pkg::sts_t sts,
  input  logic           link_ack,
  input  logic           cfg_valid,
  input  logic [2:0]     cfg_index,
  input  logic [47:0]    cfg_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [87:0]    out_tdata,
  output logic           out_tlast
);

  localparam int NW = tstf_pkg::ROOT_N_W;
  localparam int RW = tstf_pkg::ROOT_W;

  localparam tstf_pkg::sine_rom_t SINE_ROM = tstf_pkg::build_sine_rom();

  // Configuration registers.
  logic [9:0]  frame_count_r;
  logic [4:0]  frame_rate_r;
  logic [31:0] phase_step_r;
  logic [47:0] wave_r [3];

  // Per-item working registers.
  logic                     ack_r;
  logic signed [15:0]       sine_r;
  logic signed [32:0]       prod_r;
  logic signed [15:0]       pos_r [3];
  logic [34:0]              acc_r;
  logic [42:0]              t1_r;
  logic [NW-1:0]            n_r;
  logic [RW-1:0]            root_r;
  logic [RW+2:0]            rem_r;

  // Sequence state.
  logic [9:0]         frame_index_r;
  logic [31:0]        phase_accum_r;
  logic signed [15:0] prev_r [3];
  logic               first_done_r;

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;
  logic [24:0]        out_feed_r;
  logic [9:0]         out_frame_r;
  logic               out_last_r;

  // Axis-selected wave fields and table index.
  logic [47:0]                     wave_sel;
  logic [31:0]                     phase_tot;
  logic [tstf_pkg::TBL_BITS-1:0]   sine_idx;
  assign wave_sel  = wave_r[cmd.axis];
  assign phase_tot = phase_accum_r + {wave_sel[47:32], 16'd0};
  assign sine_idx  = phase_tot[31 -: tstf_pkg::TBL_BITS];

  // Position: offset plus rounded scaled product, saturated.
  logic signed [33:0] prod_bias;
  logic signed [18:0] scaled;
  logic signed [19:0] pos_sum;
  logic signed [15:0] pos_sat;
  assign prod_bias = 34'(prod_r) + 34'sd16384;
  assign scaled    = 19'(prod_bias >>> 15);
  assign pos_sum   = 20'($signed(wave_sel[31:16])) + 20'(scaled);
  always_comb begin
    if (pos_sum > 20'sd32767) begin
      pos_sat = 16'sh7FFF;
    end else if (pos_sum < -20'sd32768) begin
      pos_sat = 16'sh8000;
    end else begin
      pos_sat = pos_sum[15:0];
    end
  end

  // Squared axis difference from the prior point.
  logic signed [16:0] diff;
  logic [33:0]        diff_sq;
  logic signed [33:0] diff_prod;
  assign diff      = 17'(pos_r[cmd.axis]) - 17'(prev_r[cmd.axis]);
  assign diff_prod = diff * diff;
  assign diff_sq   = diff_prod;

  // Feed scale factor 6 * frame rate.
  logic [7:0] f6;
  assign f6 = 8'(frame_rate_r) * 8'd6;

  // One digit of the square root per step.
  logic [RW+2:0] rem_sh, trial;
  assign rem_sh = {rem_r[RW:0], n_r[NW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  // Rounded, saturated feed and frame advance.
  logic [RW:0]  root_rnd;
  logic [24:0]  feed_val;
  logic [9:0]   count_eff, frame_inc;
  logic         wrap;
  assign root_rnd  = (rem_r > (RW+3)'(root_r)) ? ((RW+1)'(root_r) + 1'b1) : (RW+1)'(root_r);
  assign count_eff = (frame_count_r == 10'd0) ? 10'd1 : frame_count_r;
  assign frame_inc = frame_index_r + 10'd1;
  assign wrap      = (frame_inc == 10'd0) || (frame_inc >= count_eff);
  always_comb begin
    if (!first_done_r) begin
      feed_val = tstf_pkg::FIRST_FEED;
    end else if (root_rnd > (RW+1)'(tstf_pkg::FEED_MAX)) begin
      feed_val = tstf_pkg::FEED_MAX;
    end else begin
      feed_val = root_rnd[24:0];
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= 10'd60;
      frame_rate_r  <= 5'd30;
      phase_step_r  <= 32'd71582788;
      wave_r[0]     <= '0;
      wave_r[1]     <= '0;
      wave_r[2]     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tstf_pkg::REG_FRAME_COUNT: frame_count_r <= cfg_data[9:0];
        tstf_pkg::REG_FRAME_RATE:  frame_rate_r  <= cfg_data[4:0];
        tstf_pkg::REG_PHASE_STEP:  phase_step_r  <= cfg_data[31:0];
        tstf_pkg::REG_U_WAVE:      wave_r[0]     <= cfg_data;
        tstf_pkg::REG_V_WAVE:      wave_r[1]     <= cfg_data;
        tstf_pkg::REG_W_WAVE:      wave_r[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ack_r <= link_ack;
      acc_r <= '0;
    end
    if (cmd.rd_sine) begin
      sine_r <= SINE_ROM[sine_idx];
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, wave_sel[15:0]}) * sine_r;
    end
    if (cmd.pos) begin
      pos_r[cmd.axis] <= pos_sat;
    end
    if (cmd.sq) begin
      acc_r <= acc_r + 35'(diff_sq);
    end
    if (cmd.scale1) begin
      t1_r <= acc_r * f6;
    end
    if (cmd.scale2) begin
      n_r    <= NW'(t1_r * f6);
      root_r <= '0;
      rem_r  <= '0;
    end
    if (cmd.root_step) begin
      n_r <= {n_r[NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  // Sequence state, updated when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_index_r <= '0;
      phase_accum_r <= '0;
      prev_r[0]     <= '0;
      prev_r[1]     <= '0;
      prev_r[2]     <= '0;
      first_done_r  <= 1'b0;
    end else if (cmd.finish) begin
      first_done_r <= 1'b1;
      if (ack_r) begin
        prev_r[0] <= pos_r[0];
        prev_r[1] <= pos_r[1];
        prev_r[2] <= pos_r[2];
        if (wrap) begin
          frame_index_r <= '0;
          phase_accum_r <= '0;
        end else begin
          frame_index_r <= frame_inc;
          phase_accum_r <= phase_accum_r + phase_step_r;
        end
      end
    end
  end

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_x_r     <= pos_r[0];
      out_y_r     <= pos_r[1];
      out_z_r     <= pos_r[2];
      out_feed_r  <= feed_val;
      out_frame_r <= frame_index_r;
      out_last_r  <= ack_r && wrap;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_frame_r, out_feed_r, out_z_r, out_y_r, out_x_r};

endmodule

// ===== rtl/three_axis_sine_trajectory_feed.sv =====
// Top level of the three-axis sine trajectory feed.
// Joins tstf_ctrl and tstf_dp; uses tstf_pkg.
//
//  Channel   Direction  Contents
//  in_*      sink       tdata[0] = link_ack
//  out_*     source     tdata = x, y, z position, feed rate, frame number; tlast = sequence end
//  cfg_*     sink       index 0..5 = frame_count, frame_rate, phase_step, u/v/w wave
//
// Per item: four steps for each of the three axes, two scale multiplies, a
// 26-step square root (one digit per cycle) and a hand-off step that waits
// until the output register is free. The next item is accepted only after the
// hand-off, back in idle. Reset is synchronous and active low; no clearing pass.
// A new item is accepted while the previous result still waits in the output
// register; the block stalls at the hand-off only if that register is still full.
module three_axis_sine_trajectory_feed (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] link_ack, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [15:0] x, [31:16] y, [47:32] z, [72:48] feed, [82:73] frame
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  tstf_pkg::cmd_t cmd;
  tstf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer.
  tstf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic, state and output register.
  tstf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .link_ack   (in_tdata[0]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/three_axis_sine_trajectory_feed_test.sv =====
// Self-checking testbench for the three-axis sine trajectory feed.
// Drives link_ack items and register writes, and predicts every point and feed rate.
// Depends on tstf_pkg and the three_axis_sine_trajectory_feed top level.
module three_axis_sine_trajectory_feed_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LUT_DEPTH   = tstf_pkg::SINE_DEPTH;
  localparam int  POINT_LAT   = 60;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [24:0]        feed;
    logic [9:0]         frame;
    logic               seq_end;
  } point_t;

  // One row of the directed table: an ack, and optionally a typed-in point.
  typedef struct {
    bit     ack;
    bit     fixed;
    point_t pt;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  three_axis_sine_trajectory_feed u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and register copies.
  logic [9:0]  frame_count_r;
  logic [4:0]  frame_rate_r;
  logic [31:0] phase_step_r;
  logic [47:0] wave_r [3];
  logic [9:0]  frame_idx;
  logic [31:0] phase_acc;
  logic signed [15:0] last_pos [3];
  bit          first_done;
  tstf_pkg::sine_rom_t sine_lut;

  point_t expected_points[$];
  int     fail_count = 0;
  longint cycle_count = 0;
  bit     rx_hold = 1'b0;
  bit     calm = 1'b0;

  // Sine table of the reference, built in the testbench's own terms.
  function automatic logic signed [15:0] sine_at(int k);
    longint unsigned p, quad, t, a, a2, u, s, q;
    p    = (longint'(k) << 32) / LUT_DEPTH;
    quad = (p >> 30) & 3;
    t    = p & 64'h3FFF_FFFF;
    if (quad[0]) begin
      t = 64'd1073741824 - t;
    end
    a  = (t * 64'd1686629713) >> 30;
    a2 = (a * a) >> 30;
    u  = 64'd1073741824 - a2 / 72;
    u  = 64'd1073741824 - ((a2 * u) >> 30) / 42;
    u  = 64'd1073741824 - ((a2 * u) >> 30) / 20;
    u  = 64'd1073741824 - ((a2 * u) >> 30) / 6;
    s  = (a * u) >> 30;
    q  = (s + 16384) >> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return quad[1] ? -$signed({1'b0, q[14:0]}) : $signed({1'b0, q[14:0]});
  endfunction

  function automatic logic signed [15:0] axis_pos(logic [47:0] wave);
    logic [31:0] total;
    longint      prod, scaled, v;
    total  = phase_acc + {wave[47:32], 16'h0};
    prod   = longint'(wave[15:0]) * longint'(sine_lut[total[31:22]]);
    scaled = (prod + 16384) >>> 15;
    v      = longint'($signed(wave[31:16])) + scaled;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint unsigned root_round(longint unsigned n);
    longint unsigned r, b, m;
    r = 0;
    b = 64'd1 << 62;
    m = n;
    while (b > m) b >>= 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (n - r * r > r) r++;
    return r;
  endfunction

  // Computes the point for one item and advances the predictor state.
  function automatic point_t next_point(bit ack);
    point_t pt;
    logic signed [15:0] p [3];
    longint d, sq;
    longint unsigned f6, fd;
    int cnt;
    for (int i = 0; i < 3; i++) p[i] = axis_pos(wave_r[i]);
    pt.x = p[0];
    pt.y = p[1];
    pt.z = p[2];
    pt.frame = frame_idx;
    pt.seq_end = 1'b0;
    if (!first_done) begin
      pt.feed = tstf_pkg::FIRST_FEED;
      first_done = 1'b1;
    end else begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        d = longint'(p[i]) - longint'(last_pos[i]);
        sq += d * d;
      end
      f6 = 6 * frame_rate_r;
      fd = root_round(sq * f6 * f6);
      pt.feed = (fd > tstf_pkg::FEED_MAX) ? tstf_pkg::FEED_MAX : fd[24:0];
    end
    if (ack) begin
      cnt = (frame_count_r == 0) ? 1 : frame_count_r;
      for (int i = 0; i < 3; i++) last_pos[i] = p[i];
      frame_idx = frame_idx + 1;
      phase_acc = phase_acc + phase_step_r;
      if (frame_idx == 0 || frame_idx >= cnt) begin
        frame_idx = '0;
        phase_acc = '0;
        pt.seq_end = 1'b1;
      end
    end
    return pt;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tstf_pkg::REG_FRAME_COUNT: frame_count_r = val[9:0];
      tstf_pkg::REG_FRAME_RATE:  frame_rate_r = val[4:0];
      tstf_pkg::REG_PHASE_STEP:  phase_step_r = val[31:0];
      tstf_pkg::REG_U_WAVE:      wave_r[0] = val;
      tstf_pkg::REG_V_WAVE:      wave_r[1] = val;
      tstf_pkg::REG_W_WAVE:      wave_r[2] = val;
      default: ;
    endcase
  endtask

  // Offers one item, with random idle gaps unless calm is set; holds valid across back-to-back items.
  task automatic send_point(bit ack, bit fixed = 0, point_t pt = '0);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, ack};
    do @(posedge clk); while (!in_tready);
    if (fixed) begin
      void'(next_point(ack));
      expected_points.push_back(pt);
    end else begin
      expected_points.push_back(next_point(ack));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (POINT_LAT) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_wave();
    return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
            16'($urandom_range(65535))};
  endfunction

  // Result side: random stall, none when calm, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // Compare each accepted point with the oldest expectation.
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point %h", out_tdata);
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (out_tdata[15:0] !== e.x) begin
          $error("x_position exp %0d got %0d", e.x, $signed(out_tdata[15:0]));
          fail_count++;
        end
        if (out_tdata[31:16] !== e.y) begin
          $error("y_position exp %0d got %0d", e.y, $signed(out_tdata[31:16]));
          fail_count++;
        end
        if (out_tdata[47:32] !== e.z) begin
          $error("z_position exp %0d got %0d", e.z, $signed(out_tdata[47:32]));
          fail_count++;
        end
        if (out_tdata[72:48] !== e.feed) begin
          $error("feed_rate exp %0d got %0d", e.feed, out_tdata[72:48]);
          fail_count++;
        end
        if (out_tdata[82:73] !== e.frame) begin
          $error("frame_number exp %0d got %0d", e.frame, out_tdata[82:73]);
          fail_count++;
        end
        if (out_tlast !== e.seq_end) begin
          $error("sequence_end exp %0d got %0d", e.seq_end, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    row_t   plan[$];
    row_t   r;
    point_t z;
    int     n;
    for (int k = 0; k < LUT_DEPTH; k++) sine_lut[k] = sine_at(k);
    frame_count_r = 10'd60;
    frame_rate_r  = 5'd30;
    phase_step_r  = 32'd71582788;
    for (int i = 0; i < 3; i++) begin
      wave_r[i] = '0;
      last_pos[i] = '0;
    end
    frame_idx = '0;
    phase_acc = '0;
    first_done = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the first point after reset is all zero with the fixed feed.
    z = '0;
    z.feed = tstf_pkg::FIRST_FEED;
    r.ack = 1; r.fixed = 1; r.pt = z;
    plan.push_back(r);
    z.feed = '0; z.frame = 10'd1;
    r.ack = 0; r.pt = z;
    plan.push_back(r);
    foreach (plan[i]) send_point(plan[i].ack, plan[i].fixed, plan[i].pt);
    drain();

    // Directed: extreme amplitudes and offsets, frame count zero, wrap on every acknowledged point.
    write_reg(tstf_pkg::REG_FRAME_COUNT, 48'd0);
    write_reg(tstf_pkg::REG_FRAME_RATE, 48'd31);
    write_reg(tstf_pkg::REG_PHASE_STEP, 48'hFFFF_FFFF);
    write_reg(tstf_pkg::REG_U_WAVE, 48'h4000_7FFF_FFFF);
    write_reg(tstf_pkg::REG_V_WAVE, 48'hFFFF_8000_FFFF);
    write_reg(tstf_pkg::REG_W_WAVE, 48'h0000_0000_0000);
    for (int i = 0; i < 6; i++) send_point(i[0]);
    drain();

    // Directed: frame rate zero gives no feed; the largest frame count.
    write_reg(tstf_pkg::REG_FRAME_RATE, 48'd0);
    write_reg(tstf_pkg::REG_FRAME_COUNT, 48'd1023);
    write_reg(tstf_pkg::REG_PHASE_STEP, 48'h0400_0000);
    for (int i = 0; i < 4; i++) send_point(1);
    drain();

    // Directed: short sequence with the slowest nonzero rate, wrap to the prior point.
    write_reg(tstf_pkg::REG_FRAME_RATE, 48'd1);
    write_reg(tstf_pkg::REG_FRAME_COUNT, 48'd3);
    for (int i = 0; i < 8; i++) send_point(i != 4);
    drain();

    // Random phases: new settings, then mostly acknowledged points.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(tstf_pkg::REG_FRAME_COUNT, (ph == 3) ? 48'd1 : $urandom_range(1023, 0));
      write_reg(tstf_pkg::REG_FRAME_RATE, $urandom_range(31, 0));
      write_reg(tstf_pkg::REG_PHASE_STEP, {16'h0, 32'($urandom())});
      write_reg(tstf_pkg::REG_U_WAVE, rand_wave());
      write_reg(tstf_pkg::REG_V_WAVE, rand_wave());
      write_reg(tstf_pkg::REG_W_WAVE, (ph == 5) ? 48'hFFFF_7FFF_FFFF : rand_wave());
      calm = (ph == 2);
      n = 100;
      if (ph == 7) begin
        // Result side holds off while items keep coming.
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < n; i++) send_point($urandom_range(99) < 85);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/tstf_pkg.sv
rtl/tstf_ctrl.sv
rtl/tstf_dp.sv
rtl/three_axis_sine_trajectory_feed.sv
tb/three_axis_sine_trajectory_feed_test.sv
